// File: rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define E3H_ASSERT_IMPL(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define E3H_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/e3h_pkg.sv
`timescale 1ns / 1ps

package e3h_pkg;

    localparam int MOMENTUM_BINS = 18;
    localparam int ETA_BINS      = 4;
    localparam int TRACK_BINS    = 4;
    localparam int COUNT_WIDTH   = 32;

    localparam int NUM_BINS  = MOMENTUM_BINS * ETA_BINS * TRACK_BINS;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int MOM_IDX_W = $clog2(MOMENTUM_BINS);
    localparam int ETA_IDX_W = $clog2(ETA_BINS);
    localparam int TRK_IDX_W = $clog2(TRACK_BINS);

    localparam int MOM_W     = 24;
    localparam int ETA_W     = 15;
    localparam int TRK_W     = 12;
    localparam int RIDX_W    = 9;
    localparam int OUT_CNT_W = 32;

    localparam logic [MOM_W-1:0] MOM_EDGES [19] = '{
        24'd3000,  24'd9600,  24'd15600, 24'd19000, 24'd24400, 24'd29800, 24'd35200,
        24'd40600, 24'd46000, 24'd51400, 24'd56800, 24'd62200, 24'd67600, 24'd73000,
        24'd78400, 24'd83800, 24'd89200, 24'd94600, 24'd100000
    };
    localparam logic signed [ETA_W-1:0] ETA_EDGES [5] = '{
        15'sd1536, 15'sd2432, 15'sd3328, 15'sd4224, 15'sd5120
    };
    localparam logic [TRK_W-1:0] TRK_EDGES [5] = '{
        12'd0, 12'd50, 12'd200, 12'd300, 12'd500
    };

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic                    action;
        logic [MOM_W-1:0]        momentum_mev;
        logic signed [ETA_W-1:0] pseudorapidity;
        logic [TRK_W-1:0]        track_count;
        logic [RIDX_W-1:0]       read_index;
    } t_in_item;

    typedef struct packed {
        logic                 accepted;
        logic [BIN_W-1:0]     bin_index;
        logic [OUT_CNT_W-1:0] bin_count;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic clear_we;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_status;

    function automatic logic [MOM_IDX_W-1:0] mom_bin(input logic [MOM_W-1:0] p);
        logic [MOM_IDX_W-1:0] b;
        b = '0;
        for (int i = 1; i < MOMENTUM_BINS; i++) begin
            if (p >= MOM_EDGES[i]) begin
                b = b + 1'b1;
            end
        end
        return b;
    endfunction

    function automatic logic [ETA_IDX_W-1:0] eta_bin(input logic signed [ETA_W-1:0] e);
        logic [ETA_IDX_W-1:0] b;
        b = '0;
        for (int i = 1; i < ETA_BINS; i++) begin
            if (e >= ETA_EDGES[i]) begin
                b = b + 1'b1;
            end
        end
        return b;
    endfunction

    function automatic logic [TRK_IDX_W-1:0] trk_bin(input logic [TRK_W-1:0] n);
        logic [TRK_IDX_W-1:0] b;
        b = '0;
        for (int i = 1; i < TRACK_BINS; i++) begin
            if (n >= TRK_EDGES[i]) begin
                b = b + 1'b1;
            end
        end
        return b;
    endfunction

    function automatic logic [BIN_W-1:0] flat_bin(
        input logic [MOM_W-1:0]        p,
        input logic signed [ETA_W-1:0] e,
        input logic [TRK_W-1:0]        n
    );
        return BIN_W'(mom_bin(p)) * BIN_W'(ETA_BINS * TRACK_BINS)
             + BIN_W'(eta_bin(e)) * BIN_W'(TRACK_BINS)
             + BIN_W'(trk_bin(n));
    endfunction

endpackage

// File: rtl/e3h_ram.sv
`timescale 1ns / 1ps

module e3h_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 288
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/e3h_ctrl.sv
`timescale 1ns / 1ps

module e3h_ctrl
    import e3h_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  t_status i_status,
    output logic    o_s_tready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.clear_we = 1'b0;
        o_cmd.update   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_we = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_READ: begin
            end
            ST_UPDATE: begin
                o_cmd.update = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/e3h_dp.sv
`timescale 1ns / 1ps

module e3h_dp
    import e3h_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  logic      i_m_tready,
    output t_status   o_status,
    output logic      o_m_tvalid,
    output t_out_item o_item
);

    logic [BIN_W-1:0]       r_clr_addr;
    logic                   r_action;
    logic                   r_drop;
    logic                   r_oob;
    logic [BIN_W-1:0]       r_addr;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [COUNT_WIDTH-1:0] rd_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic                   ram_we;
    logic [BIN_W-1:0]       ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_we) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // capture the transaction and its bin
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_item.action;
            r_drop   <= !i_item.action && (i_item.pseudorapidity < ETA_EDGES[0]);
            r_oob    <= i_item.action && (i_item.read_index >= RIDX_W'(NUM_BINS));
            if (i_item.action) begin
                r_addr <= BIN_W'(i_item.read_index);
            end else begin
                r_addr <= flat_bin(i_item.momentum_mev, i_item.pseudorapidity,
                                   i_item.track_count);
            end
        end
    end

    e3h_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd_count)
    );

    // saturating increment
    assign inc_count = (rd_count == '1) ? rd_count : rd_count + 1'b1;

    assign ram_we    = i_cmd.clear_we || (i_cmd.update && !r_action && !r_drop);
    assign ram_waddr = i_cmd.clear_we ? r_clr_addr : r_addr;
    assign ram_wdata = i_cmd.clear_we ? '0 : inc_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out.accepted  <= !r_action && !r_drop;
            r_out.bin_index <= r_drop ? '0 : r_addr;
            if (r_action) begin
                r_out.bin_count <= r_oob ? '0 : OUT_CNT_W'(rd_count);
            end else begin
                r_out.bin_count <= r_drop ? '0 : OUT_CNT_W'(inc_count);
            end
        end
    end

    assign o_status.clear_last = (r_clr_addr == LAST_BIN);
    assign o_status.out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid          = r_out_valid;
    assign o_item              = r_out;

endmodule

// File: rtl/event_3d_histogram_binner.sv
// flow: the transaction and its bin are captured, the counter ram is read through
//   its registered read port, and the result is offered once the output is free;
//   the next one waits for the read-modify-write; a stalled output holds the update
// reset: synchronous, active low; afterwards a clearing pass zeroes every counter
//   while o_s_tready stays low
`timescale 1ns / 1ps

module event_3d_histogram_binner
    import e3h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // momentum_mev, pseudorapidity, track_count, read_index, zero pad
    input  logic [63:0] i_s_tdata,
    // action
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // bin_index, bin_count, zero pad
    output logic [47:0] o_m_tdata,
    // accepted
    output logic        o_m_tuser
);

    t_in_item  in_item;
    t_out_item out_item;
    t_cmd      cmd;
    t_status   status;

    assign in_item.action         = i_s_tuser;
    assign in_item.momentum_mev   = i_s_tdata[23:0];
    assign in_item.pseudorapidity = i_s_tdata[38:24];
    assign in_item.track_count    = i_s_tdata[50:39];
    assign in_item.read_index     = i_s_tdata[59:51];

    e3h_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    e3h_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (in_item),
        .i_m_tready (i_m_tready),
        .o_status   (status),
        .o_m_tvalid (o_m_tvalid),
        .o_item     (out_item)
    );

    assign o_m_tuser = out_item.accepted;
    assign o_m_tdata = {7'd0, out_item.bin_count, out_item.bin_index};

endmodule

// File: rtl/e3h_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module e3h_checker
    import e3h_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tuser
);

    logic counted;
    logic stalled;

    assign counted = o_m_tvalid && o_m_tuser;
    assign stalled = o_m_tvalid && !i_m_tready;

    // no input transaction is taken just after reset, while counters are being cleared
    `E3H_ASSERT_NEXT(a_clear_after_reset, i_clk, 1'b0, !i_rst_n, !o_s_tready)

    // a counted event always reports a nonzero count
    `E3H_ASSERT_IMPL(a_counted_nonzero, i_clk, !i_rst_n, counted, o_m_tdata[40:9] != 32'd0)

    // a counted event lands in a real bin
    `E3H_ASSERT_IMPL(a_counted_in_range, i_clk, !i_rst_n, counted, o_m_tdata[8:0] < BIN_W'(NUM_BINS))

    `E3H_ASSERT_NEXT(a_out_hold_valid, i_clk, !i_rst_n, stalled, o_m_tvalid)

    `E3H_ASSERT_NEXT(a_out_hold_data, i_clk, !i_rst_n, stalled, $stable({o_m_tuser, o_m_tdata}))

endmodule

bind event_3d_histogram_binner e3h_checker u_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import e3h_pkg::*;

    localparam int HIST_BINS = 288;
    localparam int RANDOM_ITEMS = 440;

    // momentum edges in MeV, eta edges in 1/1024 units, track edges
    localparam int MOM_EDGE_TBL [19] = '{
        3000, 9600, 15600, 19000, 24400, 29800, 35200, 40600, 46000, 51400,
        56800, 62200, 67600, 73000, 78400, 83800, 89200, 94600, 100000
    };
    localparam int ETA_EDGE_TBL [5] = '{1536, 2432, 3328, 4224, 5120};
    localparam int TRK_EDGE_TBL [5] = '{0, 50, 200, 300, 500};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // momentum_mev, pseudorapidity, track_count, read_index, zero pad
    logic [63:0] s_tdata = '0;
    // action
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // bin_index, bin_count, zero pad
    logic [47:0] m_tdata;
    // accepted
    logic        m_tuser;

    logic [31:0] hist_counts [HIST_BINS];
    t_out_item   pending_results [$];
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int          n_binned = 0;
    int          n_dropped = 0;
    int          n_reads = 0;
    int          n_checked = 0;
    int          n_errors = 0;

    event_3d_histogram_binner u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic int count_edges_reached(input int v, input int which);
        int n;
        n = 0;
        for (int i = 1; i < 18; i++) begin
            if (which == 0 && v >= MOM_EDGE_TBL[i]) begin
                n++;
            end
            if (which == 1 && i < 4 && v >= ETA_EDGE_TBL[i]) begin
                n++;
            end
            if (which == 2 && i < 4 && v >= TRK_EDGE_TBL[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // updates the histogram copy and returns the result the block should give
    function automatic t_out_item predict_bin_result(input t_in_item it);
        t_out_item res;
        int        eta_v;
        int        idx;
        res = '0;
        eta_v = $signed(it.pseudorapidity);
        if (it.action) begin
            res.bin_index = it.read_index;
            res.bin_count = (it.read_index < HIST_BINS) ? hist_counts[it.read_index] : '0;
            n_reads++;
        end else if (eta_v < ETA_EDGE_TBL[0]) begin
            n_dropped++;
        end else begin
            idx = (count_edges_reached(int'(it.momentum_mev), 0) * 4
                + count_edges_reached(eta_v, 1)) * 4
                + count_edges_reached(int'(it.track_count), 2);
            if (hist_counts[idx] != 32'hFFFF_FFFF) begin
                hist_counts[idx] = hist_counts[idx] + 1;
            end
            res.accepted = 1'b1;
            res.bin_index = BIN_W'(idx);
            res.bin_count = hist_counts[idx];
            n_binned++;
        end
        return res;
    endfunction

    function automatic t_in_item rand_bits();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {4'b0, it.read_index, it.track_count, it.pseudorapidity, it.momentum_mev};
        do @(posedge clk); while (!s_tready);
        pending_results.insert(pending_results.size(), predict_bin_result(it));
    endtask

    task automatic send_event(input int mom, input int eta, input int trk);
        t_in_item it;
        it = '0;
        it.momentum_mev = MOM_W'(mom);
        it.pseudorapidity = ETA_W'(eta);
        it.track_count = TRK_W'(trk);
        it.read_index = RIDX_W'($urandom);
        send_item(it);
    endtask

    task automatic send_read(input int idx);
        t_in_item it;
        it = rand_bits();
        it.action = 1'b1;
        it.read_index = RIDX_W'(idx);
        send_item(it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic int near_edge(input int e);
        int v;
        v = e + $urandom_range(0, 4) - 2;
        return (v < 0) ? 0 : v;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       r;
        it = rand_bits();
        it.action = ($urandom_range(0, 99) < 20);
        r = $urandom_range(0, 99);
        if (it.action) begin
            it.read_index = (r < 10) ? RIDX_W'($urandom_range(288, 511))
                                     : RIDX_W'($urandom_range(0, HIST_BINS - 1));
            return it;
        end
        if (r < 25) begin
            // hot spot, builds up large counts in one bin
            it.momentum_mev = MOM_W'($urandom_range(20000, 24000));
            it.pseudorapidity = ETA_W'($urandom_range(2500, 3000));
            it.track_count = TRK_W'($urandom_range(60, 100));
            return it;
        end
        r = $urandom_range(0, 99);
        if (r < 20) begin
            it.momentum_mev = MOM_W'(near_edge(MOM_EDGE_TBL[$urandom_range(0, 18)]));
        end else if (r >= 30) begin
            it.momentum_mev = MOM_W'($urandom_range(0, 110000));
        end
        r = $urandom_range(0, 99);
        if (r < 15) begin
            it.pseudorapidity = ETA_W'(near_edge(ETA_EDGE_TBL[$urandom_range(0, 4)]));
        end else if (r >= 27) begin
            it.pseudorapidity = ETA_W'($urandom_range(1536, 6000));
        end
        r = $urandom_range(0, 99);
        if (r < 15) begin
            it.track_count = TRK_W'(near_edge(TRK_EDGE_TBL[$urandom_range(0, 4)]));
        end else if (r >= 25) begin
            it.track_count = TRK_W'($urandom_range(0, 600));
        end
        return it;
    endfunction

    // receiver side stalls
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && m_tvalid && m_tready) begin
            n_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, actual index %0d count %0d",
                         $time, m_tdata[8:0], m_tdata[40:9]);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.accepted) begin
                    $display("%0t: accepted mismatch, expected %0b, actual %0b",
                             $time, want.accepted, m_tuser);
                    n_errors++;
                end
                if (m_tdata[8:0] !== want.bin_index) begin
                    $display("%0t: bin_index mismatch, expected %0d, actual %0d",
                             $time, want.bin_index, m_tdata[8:0]);
                    n_errors++;
                end
                if (m_tdata[40:9] !== want.bin_count) begin
                    $display("%0t: bin_count mismatch, expected %0d, actual %0d",
                             $time, want.bin_count, m_tdata[40:9]);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_cleared_counts();
        send_read(0);
        send_read(HIST_BINS - 1);
        send_read(HIST_BINS);
        send_read(511);
    endtask

    task automatic test_bin_edges();
        send_event(0, 1536, 0);
        send_event(2999, 1535, 0);
        send_event(3000, 2431, 49);
        send_event(9599, 2432, 50);
        send_event(9600, 3327, 199);
        send_event(99999, 3328, 200);
        send_event(100000, 4223, 299);
        send_event(16777215, 4224, 300);
        send_event(16777215, 5119, 499);
        send_event(0, 5120, 500);
        send_event(16777215, 16383, 4095);
        send_event(16777215, -16384, 4095);
        send_event(50000, -1, 100);
        send_event(50000, 0, 100);
        send_event(15600, 1536, 0);
        send_event(19000, 2000, 4000);
        send_read(HIST_BINS - 1);
        send_read(0);
        send_read(1);
    endtask

    task automatic test_random_stream();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 300 && i < 400);
            if (i == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            send_item(rand_item());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_full_readback();
        for (int i = 0; i < HIST_BINS; i++) begin
            send_read(i);
        end
    endtask

    initial begin
        int guard;
        for (int i = 0; i < HIST_BINS; i++) begin
            hist_counts[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_cleared_counts();
        test_bin_edges();
        test_random_stream();
        test_full_readback();
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            n_errors++;
        end
        $display("run covered %0d binned events, %0d dropped events and %0d bin reads",
                 n_binned, n_dropped, n_reads);
        $display("%0d result transactions checked, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/e3h_pkg.sv
rtl/e3h_ram.sv
rtl/e3h_ctrl.sv
rtl/e3h_dp.sv
rtl/event_3d_histogram_binner.sv
rtl/e3h_checker.sv
tb/tb_top.sv
